// File: hw/rtl/qbs_pkg.sv
package qbs_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;

  localparam int MS_W = 16;
  localparam logic [MS_W-1:0] MS_MAX = '1;

  typedef struct packed {
    logic            cmd;
    logic [MS_W-1:0] on_time;
    logic [MS_W-1:0] off_time;
  } in_word_t;

  typedef struct packed {
    logic       led_level;
    logic       busy_res;
    logic [3:0] queued_count;
    logic       dropped;
  } out_word_t;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ENQUEUE = 1'b1;

  typedef struct packed {
    logic load;
    logic enq;
    logic tick;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic is_enq;
  } sts_t;

endpackage

// File: hw/rtl/qbs_ram.sv
module qbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/qbs_ctrl.sv
module qbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  qbs_pkg::sts_t sts,
  output logic          busy,
  output logic          out_valid,
  output qbs_pkg::ctl_t ctl
);
  import qbs_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.enq   = (sts.is_enq == CMD_ENQUEUE);
        ctl.tick  = (sts.is_enq == CMD_TICK);
        ctl.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctl.emit;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_exec_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (state_r == S_IDLE) && out_valid_r)
    else $error("exec did not finish in one cycle");
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy && $past(state_r == S_EXEC))
    else $error("result strobe without exec");
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.load, ctl.enq, ctl.tick}))
    else $error("conflicting commands");
`endif

endmodule

// File: hw/rtl/qbs_dp.sv
module qbs_dp #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qbs_pkg::ctl_t      ctl,
  input  qbs_pkg::in_word_t  in_word,
  output qbs_pkg::sts_t      sts,
  output qbs_pkg::out_word_t out_word
);
  import qbs_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  in_word_t          in_r;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [MS_W-1:0]   elapsed_r, elapsed_nxt;
  logic              led_r, led_nxt;
  out_word_t         out_r, out_nxt;

  logic [2*MS_W-1:0] head_entry;
  logic [MS_W-1:0]   elapsed_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail_idx;
  logic              wr_en;
  logic              drop;
  logic [31:0]       count_ext;

  qbs_ram #(
    .WIDTH(2 * MS_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(tail_idx),
    .wdata({in_r.on_time, in_r.off_time}),
    .raddr(head_r),
    .rdata(head_entry)
  );

  assign tail_sum    = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_idx    = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
  assign elapsed_inc = (elapsed_r == MS_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign wr_en       = ctl.enq && (count_r != FULL);
  assign drop        = ctl.enq && (count_r == FULL);

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    led_nxt     = led_r;
    if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end
    if (ctl.tick) begin
      case (phase_r)
        PH_ON: begin
          if (elapsed_inc >= head_entry[2*MS_W-1:MS_W]) begin
            led_nxt     = 1'b0;
            phase_nxt   = PH_OFF;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
        PH_OFF: begin
          if (elapsed_inc >= head_entry[MS_W-1:0]) begin
            led_nxt     = 1'b0;
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
            head_nxt    = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            phase_nxt   = PH_IDLE;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
        default: begin
          if (count_r != '0) begin
            phase_nxt   = PH_ON;
            led_nxt     = 1'b1;
            elapsed_nxt = '0;
          end
        end
      endcase
    end
  end

  assign count_ext = 32'(count_nxt);

  always_comb begin
    out_nxt.led_level    = led_nxt;
    out_nxt.busy_res     = (count_nxt != '0) || (phase_nxt != PH_IDLE);
    out_nxt.queued_count = count_ext[3:0];
    out_nxt.dropped      = drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      led_r     <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      led_r     <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_r <= in_word;
    end
    if (ctl.emit) begin
      out_r <= out_nxt;
    end
  end

  assign sts.is_enq = in_r.cmd;
  assign out_word   = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("queue count beyond depth");
  a_led_in_on: assert property (@(posedge clk) disable iff (!rst_n)
    led_r == (phase_r == PH_ON))
    else $error("led level out of step with phase");
  a_empty_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.tick && (phase_r == PH_IDLE) && (count_r == '0) |=> (phase_r == PH_IDLE))
    else $error("sequencer left idle with empty queue");
`endif

endmodule

// File: hw/rtl/queued_blink_sequencer.sv
// a result strobes out_valid for one cycle: start loads the word, the exec state runs, out_valid is registered
// a new word is taken only while idle; busy is high for the cycle after acceptance
// the exec state works from the registered input word and the registered head entry read from the queue ram
// reset: synchronous active-low rst_n clears queue pointers, sequencer phase and led
// the entry store is not cleared; the receiver cannot stall results
module queued_blink_sequencer #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  qbs_pkg::in_word_t  in_word,
  output logic               busy,
  output logic               out_valid,
  output qbs_pkg::out_word_t out_word
);
  import qbs_pkg::*;

  ctl_t ctl;
  sts_t sts;

  qbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sts      (sts),
    .busy     (busy),
    .out_valid(out_valid),
    .ctl      (ctl)
  );

  qbs_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_word (in_word),
    .sts     (sts),
    .out_word(out_word)
  );

endmodule
